### src/pu_pkg.sv
// shared constants, tables and types of the permutation unranker
`timescale 1ns / 1ps

package pu_pkg;

  localparam int SYMBOLS     = 10;
  localparam int RANK_W      = 22;
  localparam int SYM_W       = 4;
  localparam int POS_W       = 4;
  localparam int IDX_W       = $clog2(SYMBOLS);
  localparam int QW          = IDX_W;
  localparam int DIV_W       = RANK_W + 1;
  localparam int DCNT_W      = (QW > 1) ? $clog2(QW) : 1;
  localparam int IN_TDATA_W  = ((RANK_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SYM_W + POS_W + 7) / 8) * 8;

  // factorial, saturated at 2**RANK_W since no rank reaches that value
  function automatic logic [DIV_W-1:0] fact_sat(input int n);
    logic [63:0] f;
    logic [63:0] sat;
    int          i;
    sat = 64'(1) << RANK_W;
    f   = 64'(1);
    for (i = 2; i <= n; i++) begin
      f = f * 64'(i);
      if (f > sat) begin
        f = sat;
      end
    end
    return DIV_W'(f);
  endfunction

  typedef logic [DIV_W-1:0] fact_tab_t [SYMBOLS];

  function automatic fact_tab_t fact_tab_gen();
    fact_tab_t t;
    int        m;
    for (m = 0; m < SYMBOLS; m++) begin
      t[m] = fact_sat(m);
    end
    return t;
  endfunction

  // indexed by the count of symbols left after the current position
  localparam fact_tab_t        FACT_TAB = fact_tab_gen();
  localparam logic [DIV_W-1:0] FACT_ALL = fact_sat(SYMBOLS);

  typedef struct packed {
    logic              start;
    logic [RANK_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } pu_div_req_t;

  typedef struct packed {
    logic              done;
    logic [QW-1:0]     quot;
    logic [RANK_W-1:0] rem;
  } pu_div_rsp_t;

endpackage

### src/permutation_unranker_core.sv
// permutation unranker: rank in, lexicographic permutation out one symbol at a time
`timescale 1ns / 1ps

// channel  dir  tdata                      tlast         tuser
// in_      in   rank[21:0], zero pad       -             -
// out_     out  symbol[3:0], position[7:4] last_symbol   out_of_range
//
// each position: a divider pass (one quotient bit per cycle, a four-bit quotient for ten
// symbols), then the registered divider result, then the symbol is posted;
// a rank of SYMBOLS! or more skips the divider and goes straight to posting
// a new request is taken only when the sequencer is idle; the output register
// lets the next request in while the previous symbol still waits
// output back-pressure holds the sequencer in its post state, nothing is lost
// synchronous active-low reset empties the output register and idles the fsm

module permutation_unranker_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pu_pkg::IN_TDATA_W-1:0]  in_tdata,   // rank[21:0], pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pu_pkg::OUT_TDATA_W-1:0] out_tdata,  // symbol[3:0], position[7:4]
  output logic                           out_tlast,  // last_symbol
  output logic                           out_tuser   // out_of_range
);
  import pu_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              oor_r, oor_nxt;
  logic [SYM_W-1:0]  sym_r [SYMBOLS];
  logic [SYM_W-1:0]  sym_nxt [SYMBOLS];

  // output register
  logic              ovalid_r, ovalid_nxt;
  logic [SYM_W-1:0]  osym_r, osym_nxt;
  logic [POS_W-1:0]  opos_r, opos_nxt;
  logic              olast_r, olast_nxt;
  logic              ooor_r, ooor_nxt;

  pu_div_req_t       div_req;
  pu_div_rsp_t       div_rsp;

  logic              in_acc;
  logic [RANK_W-1:0] in_rank;
  logic              rank_oor;
  logic              can_put;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  qc;
  logic              final_pos;

  pu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_rank   = in_tdata[RANK_W-1:0];
  assign rank_oor  = {1'b0, in_rank} >= FACT_ALL;
  assign can_put   = !ovalid_r || out_tready;

  // index of the last remaining symbol, clamps the quotient
  assign last_idx  = IDX_W'(SYMBOLS - 1) - pos_r;
  assign qc        = (div_rsp.quot > QW'(last_idx)) ? last_idx : IDX_W'(div_rsp.quot);
  assign final_pos = (pos_r == IDX_W'(SYMBOLS - 1));

  always_comb begin
    state_nxt        = state_r;
    pos_nxt          = pos_r;
    oor_nxt          = oor_r;
    sym_nxt          = sym_r;
    ovalid_nxt       = ovalid_r && !out_tready;
    osym_nxt         = osym_r;
    opos_nxt         = opos_r;
    olast_nxt        = olast_r;
    ooor_nxt         = ooor_r;
    div_req.start    = 1'b0;
    div_req.dividend = in_rank;
    div_req.divisor  = FACT_TAB[IDX_W'(SYMBOLS - 1)];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pos_nxt = '0;
          oor_nxt = rank_oor;
          for (int j = 0; j < SYMBOLS; j++) begin
            sym_nxt[j] = SYM_W'(j);
          end
          if (rank_oor) begin
            state_nxt = S_PUT;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (can_put) begin
          ovalid_nxt = 1'b1;
          if (oor_r) begin
            // flagged rank: single result, symbol and position zero
            osym_nxt  = '0;
            opos_nxt  = '0;
            olast_nxt = 1'b1;
            ooor_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            osym_nxt  = sym_r[qc];
            opos_nxt  = POS_W'(pos_r);
            olast_nxt = final_pos;
            ooor_nxt  = 1'b0;
            // drop the chosen symbol, close the gap
            for (int j = 0; j < SYMBOLS - 1; j++) begin
              if (IDX_W'(j) >= qc) begin
                sym_nxt[j] = sym_r[j+1];
              end
            end
            if (final_pos) begin
              state_nxt = S_IDLE;
            end else begin
              pos_nxt          = pos_r + IDX_W'(1);
              div_req.start    = 1'b1;
              div_req.dividend = div_rsp.rem;
              div_req.divisor  = FACT_TAB[last_idx - IDX_W'(1)];
              state_nxt        = S_DIV;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    pos_r   <= pos_nxt;
    oor_r   <= oor_nxt;
    sym_r   <= sym_nxt;
    osym_r  <= osym_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
    ooor_r  <= ooor_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = OUT_TDATA_W'({opos_r, osym_r});
  assign out_tlast  = olast_r;
  assign out_tuser  = ooor_r;

`ifndef SYNTHESIS
  // a flagged result is alone: last, symbol and position zero
  a_oor_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == '0)
    else $error("flagged result malformed");

  // an unflagged last result sits at the final position
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && !out_tuser |->
      out_tdata[OUT_TDATA_W-1:SYM_W] == (OUT_TDATA_W - SYM_W)'(SYMBOLS - 1))
    else $error("last marker at wrong position");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider result outside wait state");

  // the chosen quotient never passes the remaining list
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUT && !oor_r |-> div_rsp.quot <= QW'(last_idx))
    else $error("quotient beyond remaining symbols");
`endif

endmodule

### src/pu_div.sv
// restoring divider, one quotient bit per cycle, small quotient
`timescale 1ns / 1ps

module pu_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pu_pkg::pu_div_req_t req,
  output pu_pkg::pu_div_rsp_t rsp
);
  import pu_pkg::*;

  localparam int DSR_W = DIV_W + QW - 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [RANK_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]     quot_r, quot_nxt;
  logic [DSR_W-1:0]  rem_ext;
  logic              ge;

  assign rem_ext = DSR_W'(rem_r);
  assign ge      = rem_ext >= dsr_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(QW - 1);
      dsr_nxt  = DSR_W'(req.divisor) << (QW - 1);
      rem_nxt  = req.dividend;
      quot_nxt = '0;
    end else if (busy_r) begin
      // trial subtract of the shifted divisor
      if (ge) begin
        rem_nxt = RANK_W'(rem_ext - dsr_r);
      end
      quot_nxt = QW'({quot_r, ge});
      dsr_nxt  = dsr_r >> 1;
      cnt_nxt  = cnt_r - DCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

### bench/permutation_unranker_checker.sv
// checker for the permutation unranker: predicts each permutation and compares the symbols
`timescale 1ns / 1ps

module permutation_unranker_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [pu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [pu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                           out_tlast,
  input  logic                           out_tuser,
  output int                             fail_count,
  output int                             symbols_outstanding
);

  import pu_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] position;
    logic             last_symbol;
    logic             out_of_range;
  } perm_symbol_t;

  perm_symbol_t expected_symbols[$];
  int           errors;

  initial begin
    errors              = 0;
    fail_count          = 0;
    symbols_outstanding = 0;
  end

  function automatic longint factorial(input int n);
    longint f;
    int     i;
    f = 1;
    for (i = 2; i <= n; i++) begin
      f = f * i;
    end
    return f;
  endfunction

  // walks the factorial digits of the rank, picking from the unused symbols
  function automatic void predict_permutation(input logic [RANK_W-1:0] rank);
    logic [SYM_W-1:0] unused_syms [SYMBOLS];
    longint           rest;
    longint           f;
    longint           q;
    int               left;
    int               idx;
    int               k;
    int               pos;
    perm_symbol_t     step;
    for (k = 0; k < SYMBOLS; k++) begin
      unused_syms[k] = SYM_W'(k);
    end
    rest = longint'(rank);
    if (rest >= factorial(SYMBOLS)) begin
      step = '{symbol: '0, position: '0, last_symbol: 1'b1, out_of_range: 1'b1};
      expected_symbols.push_back(step);
      return;
    end
    left = SYMBOLS;
    for (pos = 0; pos < SYMBOLS; pos++) begin
      f = factorial(left - 1);
      q = rest / f;
      if (q >= left) begin
        q = left - 1;
      end
      idx               = int'(q);
      step.symbol       = unused_syms[idx];
      step.position     = POS_W'(pos);
      step.last_symbol  = (pos == SYMBOLS - 1);
      step.out_of_range = 1'b0;
      for (k = idx; k + 1 < left; k++) begin
        unused_syms[k] = unused_syms[k + 1];
      end
      left--;
      rest = rest % f;
      expected_symbols.push_back(step);
    end
  endfunction

  always @(posedge clk) begin
    perm_symbol_t got;
    perm_symbol_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_permutation(in_tdata[RANK_W-1:0]);
      end
      if (out_tvalid && out_tready) begin
        got = '{symbol:       out_tdata[SYM_W-1:0],
                position:     out_tdata[SYM_W+POS_W-1:SYM_W],
                last_symbol:  out_tlast,
                out_of_range: out_tuser};
        if (expected_symbols.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: unexpected symbol %0d pos %0d last %b oor %b", $realtime,
                     got.symbol, got.position, got.last_symbol, got.out_of_range);
          end
        end else begin
          want = expected_symbols.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("%0t: mismatch exp sym %0d pos %0d last %b oor %b, got sym %0d pos %0d last %b oor %b",
                       $realtime, want.symbol, want.position, want.last_symbol,
                       want.out_of_range, got.symbol, got.position, got.last_symbol,
                       got.out_of_range);
            end
          end
        end
      end
    end
    fail_count          <= errors;
    symbols_outstanding <= expected_symbols.size();
  end

endmodule

### bench/permutation_unranker_core_tb.sv
// testbench top for the permutation unranker: stimulus, back-pressure, watchdog and verdict
`timescale 1ns / 1ps

module permutation_unranker_core_tb;

  import pu_pkg::*;

  // 10! for the ten-symbol build: first rank that gets flagged out of range
  localparam int unsigned RANK_LIMIT    = 3628800;
  localparam int unsigned RANK_MAX      = (1 << RANK_W) - 1;
  localparam int          RANDOM_PHASE  = 80;
  localparam int          HOLD_OFF      = 500;
  localparam int          WATCHDOG_MAX  = 4000;
  localparam int          SETTLE_CYCLES = 150;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;

  int   fail_count;
  int   symbols_outstanding;
  int   idle_pct;
  int   stall_pct;
  logic hold_now;
  logic hold_served;
  int   quiet_cycles;

  permutation_unranker_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  permutation_unranker_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tlast           (out_tlast),
    .out_tuser           (out_tuser),
    .fail_count          (fail_count),
    .symbols_outstanding (symbols_outstanding)
  );

  // 12 ns period
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // offers one rank request, called and returning on a falling edge
  task automatic send_rank(input logic [RANK_W-1:0] rank);
    // random idle cycles ahead of the request
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - RANK_W){1'b0}}, rank};
    // request is taken at the first rising edge with ready high
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // mostly in-range ranks, a slice of flagged ones and a few tiny ones
  function automatic logic [RANK_W-1:0] pick_rank();
    int sel;
    sel = $urandom_range(99);
    if (sel < 78) begin
      return RANK_W'($urandom_range(RANK_LIMIT - 1, 0));
    end else if (sel < 90) begin
      return RANK_W'($urandom_range(RANK_MAX, RANK_LIMIT));
    end else begin
      return RANK_W'($urandom_range(150, 0));
    end
  endfunction

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    out_tready  = 1'b0;
    hold_served = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_now && !hold_served) begin
        // block fills up and has to push back on the input side
        hold_served = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF - 1) @(negedge clk);
      end else begin
        out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog: ends the run after too many cycles with no request moving
  initial begin
    quiet_cycles = 0;
    wait (rst_n === 1'b1);
    while (quiet_cycles < WATCHDOG_MAX) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("permutation_unranker_core test failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [RANK_W-1:0] directed_ranks [] = '{
      // first ranks and factorial boundaries of the lower positions
      22'd0, 22'd1, 22'd2, 22'd5, 22'd6, 22'd23, 22'd24, 22'd119, 22'd120,
      22'd40319, 22'd40320, 22'd362879, 22'd362880, 22'd1814399, 22'd1814400,
      // top bit alone and alternating bit patterns
      22'd2097152, 22'h2AAAAA, 22'h155555,
      // last permutations, then ranks past the end of the table
      22'd3628798, 22'd3628799, 22'd3628800, 22'd3628801, 22'd4194302, 22'd4194303
    };
    int phase_idle [4]  = '{0, 59, 0, 20};
    int phase_stall [4] = '{0, 0, 59, 20};
    int p;
    int n;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_now  = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed ranks, no idling on either side
    foreach (directed_ranks[i]) begin
      send_rank(directed_ranks[i]);
    end

    // random phases with the different idle and stall mixes
    for (p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      // long receiver hold-off while requests keep coming, no idling otherwise
      if (p == 0) begin
        hold_now = 1'b1;
      end
      for (n = 0; n < RANDOM_PHASE; n++) begin
        send_rank(pick_rank());
      end
    end
    in_tvalid <= 1'b0;

    // drain, then give stray symbols a chance to show up
    while (symbols_outstanding != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fail_count == 0 && symbols_outstanding == 0) begin
      $display("permutation_unranker_core test passed");
    end else begin
      $display("permutation_unranker_core test failed");
    end
    $finish;
  end

endmodule
